[sv/spsm_pkg.sv]
// Package with the constants, request codes and status codes of the slotted page space manager.
`timescale 1ns / 1ps
`default_nettype none

package spsm_pkg;

    localparam int PAGE_BYTES   = 4096;
    localparam int HEADER_BYTES = 12;
    localparam int SLOT_BYTES   = 6;
    localparam int MAX_SLOTS    = 512;

    localparam int ACTION_W = 2;
    localparam int SIZE_W   = 13;
    localparam int SLOT_W   = 9;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 10;
    localparam int CALC_W   = SIZE_W + 1;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 48;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_DELETE = 2'd1,
        ACT_LOOKUP = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_INVALID  = 2'd2,
        ST_DELETED  = 2'd3
    } status_t;

    typedef struct packed {
        logic              deleted;
        logic [SIZE_W-1:0] size;
        logic [SIZE_W-1:0] offset;
    } slot_entry_t;

endpackage

`default_nettype wire

[sv/slotted_page_space_manager.sv]
// Top level of the slotted page space manager with its slot table memory and request sequencer.
// A result is registered on the m_ side by the update step that follows the accepted request.
// A new request is taken only after that step: the slot table memory is read when a request
// is accepted, and the update step then writes the table, the free pointer and the counters.
// A result waiting on the m_ side stalls the update cycle of the following request.
// Reset empties the page at once; the slot table memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module slotted_page_space_manager (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // action [1:0], byte_len [14:2], slot_index [23:15]
    input  wire logic [spsm_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // status [1:0], result_slot [10:2], entry_offset [23:11], stored_size [36:24],
    // deleted_total [46:37], zero [47]
    output logic [spsm_pkg::M_DATA_W-1:0]       m_tdata
);

    localparam int SW = spsm_pkg::SIZE_W;
    localparam int CW = spsm_pkg::CALC_W;
    localparam int NW = spsm_pkg::COUNT_W;
    localparam int IW = spsm_pkg::SLOT_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                         state_reg;
    logic [SW-1:0]                  free_ptr_reg, free_ptr_next;
    logic [NW-1:0]                  slot_count_reg, slot_count_next;
    logic [NW-1:0]                  del_count_reg, del_count_next;
    spsm_pkg::action_t              req_action_reg;
    logic [SW-1:0]                  req_raw_reg;
    logic [IW-1:0]                  req_slot_reg;
    logic                           m_tvalid_reg;
    logic [spsm_pkg::M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    spsm_pkg::slot_entry_t          slot_mem [spsm_pkg::MAX_SLOTS];
    spsm_pkg::slot_entry_t          rd_entry_reg;
    spsm_pkg::slot_entry_t          wr_entry;
    logic                           mem_we;
    logic [IW-1:0]                  mem_waddr;

    logic                           s_accept;
    logic                           exec_go;
    logic [CW-1:0]                  padded;
    logic [CW-1:0]                  dir_end;
    logic [CW-1:0]                  free_ext;
    logic                           no_space;
    logic                           bad_slot;
    spsm_pkg::status_t              res_status;
    logic [IW-1:0]                  res_slot;
    logic [SW-1:0]                  res_offset;
    logic [SW-1:0]                  res_size;
    logic [NW-1:0]                  res_deleted;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign exec_go  = (state_reg == S_EXEC) && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign padded   = ({1'b0, req_raw_reg} + CW'(7)) & ~CW'(7);
    assign dir_end  = CW'(spsm_pkg::HEADER_BYTES)
                    + (CW'(slot_count_reg) + CW'(1)) * CW'(spsm_pkg::SLOT_BYTES);
    assign free_ext = {1'b0, free_ptr_reg};
    assign no_space = (slot_count_reg >= NW'(spsm_pkg::MAX_SLOTS))
                   || (free_ext < dir_end)
                   || ((free_ext - dir_end) < padded);
    assign bad_slot = ({1'b0, req_slot_reg} >= slot_count_reg);

    always_comb begin
        free_ptr_next   = free_ptr_reg;
        slot_count_next = slot_count_reg;
        del_count_next  = del_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = req_slot_reg;
        wr_entry        = rd_entry_reg;
        res_status      = spsm_pkg::ST_OK;
        res_slot        = req_slot_reg;
        res_offset      = rd_entry_reg.offset;
        res_size        = rd_entry_reg.size;
        res_deleted     = del_count_reg;
        unique case (req_action_reg)
            spsm_pkg::ACT_INSERT: begin
                if (no_space) begin
                    res_status = spsm_pkg::ST_NO_SPACE;
                    res_slot   = '0;
                    res_offset = '0;
                    res_size   = '0;
                end else begin
                    free_ptr_next    = free_ptr_reg - padded[SW-1:0];
                    slot_count_next  = slot_count_reg + NW'(1);
                    mem_we           = 1'b1;
                    mem_waddr        = slot_count_reg[IW-1:0];
                    wr_entry.deleted = 1'b0;
                    wr_entry.size    = padded[SW-1:0];
                    wr_entry.offset  = free_ptr_next;
                    res_slot         = slot_count_reg[IW-1:0];
                    res_offset       = free_ptr_next;
                    res_size         = padded[SW-1:0];
                end
            end
            spsm_pkg::ACT_CLEAR: begin
                free_ptr_next   = SW'(spsm_pkg::PAGE_BYTES);
                slot_count_next = '0;
                del_count_next  = '0;
                res_slot        = '0;
                res_offset      = '0;
                res_size        = '0;
                res_deleted     = '0;
            end
            spsm_pkg::ACT_DELETE, spsm_pkg::ACT_LOOKUP: begin
                if (bad_slot) begin
                    res_status = spsm_pkg::ST_INVALID;
                    res_offset = '0;
                    res_size   = '0;
                end else if (rd_entry_reg.deleted) begin
                    res_status = spsm_pkg::ST_DELETED;
                end else if (req_action_reg == spsm_pkg::ACT_DELETE) begin
                    mem_we           = 1'b1;
                    wr_entry.deleted = 1'b1;
                    del_count_next   = del_count_reg + NW'(1);
                    res_deleted      = del_count_next;
                end
            end
            default: begin
            end
        endcase
        m_tdata_next = {1'b0, res_deleted, res_size, res_offset, res_slot, res_status};
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_entry_reg <= slot_mem[s_tdata[23:15]];
        end
        if (exec_go && mem_we) begin
            slot_mem[mem_waddr] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            m_tvalid_reg   <= 1'b0;
            free_ptr_reg   <= SW'(spsm_pkg::PAGE_BYTES);
            slot_count_reg <= '0;
            del_count_reg  <= '0;
        end else begin
            if (exec_go) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_accept) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_go) begin
                        state_reg      <= S_IDLE;
                        free_ptr_reg   <= free_ptr_next;
                        slot_count_reg <= slot_count_next;
                        del_count_reg  <= del_count_next;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_action_reg <= spsm_pkg::action_t'(s_tdata[1:0]);
            req_raw_reg    <= s_tdata[14:2];
            req_slot_reg   <= s_tdata[23:15];
        end
        if (exec_go) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

`default_nettype wire
